>>> design/wtm_pkg.sv
package wtm_pkg;
    localparam int MAX_LAYERS   = 4;
    localparam int CURVE_POINTS = 11;

    localparam int MOIST_W   = 26;
    localparam int LEVEL_W   = 22;
    localparam int THICK_W   = 19;
    localparam int CAP_W     = 24;
    localparam int SAMPLE_W  = 24;
    localparam int QUO_W     = 50;

    localparam logic [1:0] ACT_POINT  = 2'd0;
    localparam logic [1:0] ACT_LAYER  = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    localparam logic [1:0] KIND_LAYER  = 2'd0;
    localparam logic [1:0] KIND_LOWEST = 2'd1;
    localparam logic [1:0] KIND_UPPER  = 2'd2;
    localparam logic [1:0] KIND_ALL    = 2'd3;

    localparam logic REG_LAYER_COUNT = 1'b0;
    localparam logic REG_SAT_MARGIN  = 1'b1;

    typedef struct packed {
        logic start;
        logic signed [49:0] num;
        logic [26:0] den;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic signed [49:0] quo;
    } t_div_rsp;

    function automatic logic signed [LEVEL_W-1:0] sat_level(input logic signed [51:0] v);
        if (v < -52'sd2097152) begin
            return -22'sd2097152;
        end else if (v > 52'sd2097151) begin
            return 22'sd2097151;
        end
        return v[LEVEL_W-1:0];
    endfunction
endpackage

>>> design/wtm_ram.sv
module wtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/wtm_div.sv
module wtm_div
    import wtm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    // Restoring divide, one quotient bit per cycle, magnitudes then sign fix.
    logic [49:0] r_rem_q;
    logic [27:0] r_rem;
    logic [26:0] r_den;
    logic        r_neg;
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [27:0] w_trial;
    logic [28:0] w_diff;
    logic [49:0] w_mag;

    assign w_mag   = i_req.num[49] ? 50'(-i_req.num) : 50'(i_req.num);
    assign w_trial = {r_rem[26:0], r_rem_q[49]};
    assign w_diff  = {1'b0, w_trial} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem_q <= w_mag;
            r_rem   <= '0;
            r_den   <= i_req.den;
            r_neg   <= i_req.num[49];
        end else if (r_busy) begin
            if (!w_diff[28]) begin
                r_rem   <= w_diff[27:0];
                r_rem_q <= {r_rem_q[48:0], 1'b1};
            end else begin
                r_rem   <= w_trial;
                r_rem_q <= {r_rem_q[48:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? -$signed(r_rem_q) : $signed(r_rem_q);
endmodule

>>> design/water_table_from_moisture_curves_unit.sv
// Water table levels from moisture-versus-level curves.
// Input stream (s_axis): one item per transfer, action in tuser. Action 0 loads
// a curve point, action 1 loads a layer's thickness and capacity, action 2
// stores a layer's moisture sample. A sample for the bottom layer in use starts
// a column run.
// Output stream (m_axis): a run gives one level per layer in layer order, then
// the lowest unsaturated level, the lumped upper level and the lumped all
// level, with the result kind in tuser and tlast on the final one.
// Load items and samples that start no run leave the sequencer idle, so
// s_axis_tready stays high. A run does L+2 curve lookups (L layers in use);
// each walks the curve from the dry end one point at a time (one RAM read
// port) and, unless it stops on the first point read or meets a zero-width
// interval, then divides through a 50-step bit-serial divider. s_axis_tready
// is low for the whole run. Results leave through a single output register;
// a stall on m_axis_tready holds the run in place and nothing is dropped.
// Reset (i_rst_n low, synchronous) sets layer_count to 3, saturation_margin to
// 0 and idles the sequencer. Curve and layer stores are not cleared.
// Configuration: i_cfg_we with i_cfg_index 0 (layer_count) or 1 (margin).
module water_table_from_moisture_curves_unit
    import wtm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // curve_number[2:0], point_number[6:3], point_moisture[32:7],
    // point_level[54:33], layer_number[56:55], layer_thickness[75:57],
    // layer_capacity[99:76], moisture[123:100], zero pad to 128
    input  logic [127:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_layer[1:0], water_level[23:2], level_present[24], zero pad to 32
    output logic [31:0] m_axis_tdata,
    // result_kind[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    localparam int NCURVE = MAX_LAYERS + 2;
    localparam int DEPTH  = NCURVE * CURVE_POINTS;
    localparam int AW     = $clog2(DEPTH);
    localparam int PW     = $clog2(CURVE_POINTS + 1);
    localparam int LW     = $clog2(MAX_LAYERS + 1);
    localparam int LIW    = $clog2(MAX_LAYERS);
    localparam int SW     = SAMPLE_W + LW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_LSTART = 4'd2;
    localparam logic [3:0] S_LREAD  = 4'd3;
    localparam logic [3:0] S_LCMP   = 4'd4;
    localparam logic [3:0] S_LNEXT  = 4'd5;
    localparam logic [3:0] S_LDIV   = 4'd6;
    localparam logic [3:0] S_LWAIT  = 4'd7;
    localparam logic [3:0] S_LDONE  = 4'd8;
    localparam logic [3:0] S_SCAN   = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;
    localparam logic [3:0] S_WAITO  = 4'd11;

    // unpack
    logic [1:0]  w_action;
    logic [2:0]  w_curve;
    logic [3:0]  w_point;
    logic [1:0]  w_layer;
    assign w_action = s_axis_tuser;
    assign w_curve  = s_axis_tdata[2:0];
    assign w_point  = s_axis_tdata[6:3];
    assign w_layer  = s_axis_tdata[56:55];

    logic [2:0] r_layer_count;
    logic [9:0] r_margin;
    logic [3:0] r_state;

    logic [THICK_W-1:0]  r_thick [MAX_LAYERS];
    logic [CAP_W-1:0]    r_cap   [MAX_LAYERS];
    logic [SAMPLE_W-1:0] r_moist [MAX_LAYERS];
    logic signed [LEVEL_W-1:0] r_lvl [MAX_LAYERS];
    logic [MAX_LAYERS-1:0]     r_ok;

    logic [LW-1:0] w_nl;
    always_comb begin
        if (r_layer_count == 3'd0) begin
            w_nl = LW'(1);
        end else if (32'(r_layer_count) > MAX_LAYERS) begin
            w_nl = LW'(MAX_LAYERS);
        end else begin
            w_nl = LW'(r_layer_count);
        end
    end

    logic [LIW-1:0] w_bot;
    assign w_bot = LIW'(w_nl - LW'(1));

    logic w_in_fire;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    // curve store: moisture and level share address
    logic          w_we;
    logic [AW-1:0] w_waddr, r_raddr;
    logic [MOIST_W-1:0] w_rm;
    logic [LEVEL_W-1:0] w_rz;
    assign w_we = w_in_fire && w_action == ACT_POINT && 32'(w_curve) < NCURVE
                  && 32'(w_point) < CURVE_POINTS;
    assign w_waddr = AW'(32'(w_curve) * CURVE_POINTS + 32'(w_point));

    wtm_ram #(.WIDTH(MOIST_W), .DEPTH(DEPTH)) u_ram_m (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr),
        .i_wdata(s_axis_tdata[32:7]), .i_raddr(r_raddr), .o_rdata(w_rm));
    wtm_ram #(.WIDTH(LEVEL_W), .DEPTH(DEPTH)) u_ram_z (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr),
        .i_wdata(s_axis_tdata[54:33]), .i_raddr(r_raddr), .o_rdata(w_rz));

    t_div_req w_dreq;
    t_div_rsp w_drsp;
    wtm_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    // lookup sequencing
    logic [2:0]          r_job;     // 0..nl-1 layers, then upper, then all
    logic [SW-1:0]       r_key;
    logic [SW-1:0]       r_sum_up, r_sum_all;
    logic [PW-1:0]       r_i;
    logic [MOIST_W-1:0]  r_m_lo, r_m_hi;
    logic signed [LEVEL_W-1:0] r_z_lo, r_z_hi;
    logic signed [LEVEL_W-1:0] r_res, r_z2, r_z3, r_z1;
    logic                r_res_ok;
    logic [THICK_W+LW-1:0] r_total, r_tmp;
    logic [LW:0]         r_li;
    logic [LW:0]         r_emit;
    logic                r_ov;
    logic [31:0]         r_od;
    logic [1:0]          r_ou;
    logic                r_ol;
    logic [LW-1:0]       r_acc_idx;

    logic signed [27:0] w_den;
    logic signed [49:0] w_num;
    logic [SW:0]        w_key_ext;
    assign w_den = $signed({2'b0, r_m_hi}) - $signed({2'b0, r_m_lo});
    assign w_num = 50'(($signed({r_z_hi[21], r_z_hi}) - $signed({r_z_lo[21], r_z_lo}))
                   * ($signed({1'b0, r_key}) - $signed({1'b0, r_m_lo})));
    assign w_key_ext = {1'b0, r_key};
    // divider takes a positive denominator: move its sign onto the numerator
    assign w_dreq.start = (r_state == S_LDIV) && w_den != 0;
    assign w_dreq.num   = w_den[27] ? -w_num : w_num;
    assign w_dreq.den   = w_den[27] ? 27'(-w_den) : w_den[26:0];

    logic w_sat;
    logic [LIW-1:0] w_li;
    assign w_li  = r_li[LIW-1:0];
    assign w_sat = ($signed({2'b0, r_cap[w_li]}) - $signed({2'b0, r_moist[w_li]}))
                   <= $signed({16'b0, r_margin});

    logic signed [LEVEL_W-1:0] w_negtot;
    assign w_negtot = sat_level(-$signed(52'(r_total)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_layer_count <= 3'd3;
            r_margin      <= '0;
            r_ov          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_LAYER_COUNT: r_layer_count <= i_cfg_data[2:0];
                    REG_SAT_MARGIN:  r_margin      <= i_cfg_data;
                    default: ;
                endcase
            end
            // the emit state drives the output valid itself
            if (r_ov && m_axis_tready && r_state != S_EMIT) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire && w_action == ACT_SAMPLE
                            && 32'(w_layer) < MAX_LAYERS
                            && LW'(w_layer) == w_nl - LW'(1)) begin
                        r_state   <= S_PREP;
                        r_acc_idx <= '0;
                        r_total   <= '0;
                        r_sum_up  <= '0;
                        r_sum_all <= '0;
                    end
                end
                S_PREP: begin
                    // one layer per cycle into the running sums
                    r_total   <= r_total + (THICK_W+LW)'(r_thick[r_acc_idx[LIW-1:0]]);
                    r_sum_all <= r_sum_all + SW'(r_moist[r_acc_idx[LIW-1:0]]);
                    if (r_acc_idx + LW'(1) != w_nl) begin
                        r_sum_up <= r_sum_up + SW'(r_moist[r_acc_idx[LIW-1:0]]);
                    end
                    if (r_acc_idx + LW'(1) == w_nl) begin
                        r_job   <= '0;
                        r_state <= S_LSTART;
                    end
                    r_acc_idx <= r_acc_idx + LW'(1);
                end
                S_LSTART: begin
                    if (32'(r_job) < 32'(w_nl)) begin
                        r_key <= SW'(r_moist[r_job[LIW-1:0]]);
                    end else if (32'(r_job) == 32'(w_nl)) begin
                        r_key <= r_sum_up;
                    end else begin
                        r_key <= r_sum_all;
                    end
                    r_i     <= PW'(CURVE_POINTS - 1);
                    r_raddr <= AW'(32'(r_job) * CURVE_POINTS + CURVE_POINTS - 1);
                    r_state <= S_LREAD;
                end
                S_LREAD: r_state <= S_LCMP;
                S_LCMP: begin
                    if (r_i != '0 && w_key_ext > (SW+1)'(w_rm)) begin
                        r_m_lo  <= w_rm;
                        r_z_lo  <= w_rz;
                        r_i     <= r_i - PW'(1);
                        r_raddr <= r_raddr - AW'(1);
                        r_state <= S_LREAD;
                    end else if (32'(r_i) == CURVE_POINTS - 1) begin
                        r_res_ok <= (w_key_ext == (SW+1)'(w_rm));
                        r_res    <= w_rz;
                        r_state  <= S_LDONE;
                    end else begin
                        r_m_hi  <= w_rm;
                        r_z_hi  <= w_rz;
                        r_state <= S_LNEXT;
                    end
                end
                S_LNEXT: r_state <= S_LDIV;
                S_LDIV: begin
                    r_res_ok <= 1'b1;
                    if (w_den == 0) begin
                        r_res   <= r_z_hi;
                        r_state <= S_LDONE;
                    end else begin
                        r_state <= S_LWAIT;
                    end
                end
                S_LWAIT: begin
                    if (w_drsp.done) begin
                        r_res   <= sat_level(52'($signed(r_z_lo)) + 52'(w_drsp.quo));
                        r_state <= S_LDONE;
                    end
                end
                S_LDONE: begin
                    if (32'(r_job) < 32'(w_nl)) begin
                        if (32'(r_job) == 32'(w_nl) - 1 && !r_res_ok) begin
                            r_lvl[r_job[LIW-1:0]] <= w_negtot;
                            r_ok[r_job[LIW-1:0]]  <= 1'b1;
                        end else begin
                            r_lvl[r_job[LIW-1:0]] <= r_res;
                            r_ok[r_job[LIW-1:0]]  <= r_res_ok;
                        end
                    end else if (32'(r_job) == 32'(w_nl)) begin
                        r_z2 <= r_res_ok ? r_res : r_lvl[w_bot];
                    end else begin
                        r_z3 <= r_res_ok ? r_res : w_negtot;
                    end
                    if (32'(r_job) == 32'(w_nl) + 1) begin
                        r_li    <= (LW+1)'(w_nl) - (LW+1)'(1);
                        r_tmp   <= r_total;
                        r_state <= S_SCAN;
                    end else begin
                        r_job   <= r_job + 3'd1;
                        r_state <= S_LSTART;
                    end
                end
                S_SCAN: begin
                    if (r_li[LW]) begin
                        r_z1    <= '0;
                        r_emit  <= '0;
                        r_state <= S_EMIT;
                    end else if (w_sat) begin
                        r_tmp <= r_tmp - (THICK_W+LW)'(r_thick[w_li]);
                        r_li  <= r_li - (LW+1)'(1);
                    end else begin
                        r_z1    <= r_ok[w_li] ? r_lvl[w_li]
                                   : sat_level(-$signed(52'(r_tmp)));
                        r_emit  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_ov || m_axis_tready) begin
                        r_ov <= 1'b1;
                        r_ol <= 1'b0;
                        if (r_emit < (LW+1)'(w_nl)) begin
                            r_od <= {7'b0, r_ok[r_emit[LIW-1:0]],
                                     r_ok[r_emit[LIW-1:0]] ? r_lvl[r_emit[LIW-1:0]] : 22'sd0,
                                     2'(r_emit)};
                            r_ou <= KIND_LAYER;
                        end else if (r_emit == (LW+1)'(w_nl)) begin
                            r_od <= {7'b0, 1'b1, r_z1, 2'b0};
                            r_ou <= KIND_LOWEST;
                        end else if (r_emit == (LW+1)'(w_nl) + (LW+1)'(1)) begin
                            r_od <= {7'b0, 1'b1, r_z2, 2'b0};
                            r_ou <= KIND_UPPER;
                        end else begin
                            r_od    <= {7'b0, 1'b1, r_z3, 2'b0};
                            r_ou    <= KIND_ALL;
                            r_ol    <= 1'b1;
                            r_state <= S_WAITO;
                        end
                        r_emit <= r_emit + (LW+1)'(1);
                    end
                end
                S_WAITO: begin
                    if (!r_ov || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire && 32'(w_layer) < MAX_LAYERS) begin
            if (w_action == ACT_LAYER) begin
                r_thick[w_layer] <= s_axis_tdata[75:57];
                r_cap[w_layer]   <= s_axis_tdata[99:76];
            end else if (w_action == ACT_SAMPLE) begin
                r_moist[w_layer] <= s_axis_tdata[123:100];
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tuser  = r_ou;
    assign m_axis_tlast  = r_ol;

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !s_axis_tready) else $error("ready while busy");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !m_axis_tready |=> r_ov && $stable(r_od)) else $error("output lost");
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_ol |-> r_ou == KIND_ALL) else $error("tlast kind");
endmodule
